// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the moving-average block, clocked on clk_i and
// disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define MSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// expression must never be true out of reset
`define MSA_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// File: sv/msa_pkg.sv
// ----------------------------------------------------------------------------
// msa_pkg
// Shared widths, types and constants of the six-axis moving-average filter
// ----------------------------------------------------------------------------
`default_nettype none

package msa_pkg;

  // window length and axis count
  localparam int WINDOW = 12;
  localparam int AXES   = 6;
  localparam int DATA_W = 24;

  // running sum, magnitude and fill counter widths
  localparam int SUM_W  = DATA_W + $clog2(WINDOW) + 1;
  localparam int MAG_W  = SUM_W - 1;
  localparam int CNT_W  = $clog2(WINDOW);
  localparam int PROD_W = 2 * MAG_W;

  // rounding offset and reciprocal of the window length
  localparam int HALF_WIN = WINDOW / 2;
  localparam logic [MAG_W-1:0] RECIP = MAG_W'((longint'(1) << MAG_W) / WINDOW);

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef sample_t axes_t [AXES];
  typedef sum_t    sums_t [AXES];

  // load enables of the two divide stages
  typedef struct packed {
    logic mul_en;
    logic fix_en;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// File: sv/msa_cell.sv
// ----------------------------------------------------------------------------
// msa_cell
// One slot of the sample history: holds a six-axis sample and hands it to
// the next slot whenever a new item enters the window
// ----------------------------------------------------------------------------
`default_nettype none

module msa_cell import msa_pkg::*; (
  input  logic  clk_i,
  input  logic  shift_i,
  input  axes_t data_i,
  output axes_t data_o
);

  axes_t data_q;

  // sample register, payload only
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// File: sv/msa_mean.sv
// ----------------------------------------------------------------------------
// msa_mean
// Rounded division of one axis sum by the window length: reciprocal
// multiply in the first stage, remainder correction and sign in the second
// ----------------------------------------------------------------------------
`default_nettype none

module msa_mean import msa_pkg::*; (
  input  logic      clk_i,
  input  pipe_ctl_t ctl_i,
  input  sum_t      sum_i,
  output sample_t   mean_o
);

  logic [SUM_W-1:0]  abs_sum;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  x_q;
  logic [DATA_W-1:0] q_est_q;
  logic              neg_q;
  logic [MAG_W-1:0]  back;
  logic [MAG_W-1:0]  rem;
  logic [DATA_W-1:0] q_fix;
  sample_t           mean_q;

  // magnitude plus half window, then reciprocal estimate (low by at most one)
  always_comb begin
    abs_sum = sum_i[SUM_W-1] ? (~sum_i + 1'b1) : sum_i;
    mag     = abs_sum[MAG_W-1:0] + MAG_W'(HALF_WIN);
    prod    = PROD_W'(mag) * PROD_W'(RECIP);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      x_q     <= mag;
      q_est_q <= prod[MAG_W +: DATA_W];
      neg_q   <= sum_i[SUM_W-1];
    end
  end

  // remainder check bumps the estimate, then restore the sign
  always_comb begin
    back  = MAG_W'(q_est_q) * MAG_W'(WINDOW);
    rem   = x_q - back;
    q_fix = q_est_q + DATA_W'(rem >= MAG_W'(WINDOW));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fix_en) begin
      mean_q <= neg_q ? sample_t'(~q_fix + 1'b1) : sample_t'(q_fix);
    end
  end

  assign mean_o = mean_q;

endmodule

`default_nettype wire

// File: sv/six_axis_moving_average_top.sv
// ----------------------------------------------------------------------------
// six_axis_moving_average_top
// Boxcar moving average over six force/torque axes with running sums
//
//   channel | direction | handshake                 | payload
//   input   | in        | in_valid_i / in_ready_o   | force_x_i .. torque_z_i
//   result  | out       | out_valid_o / out_ready_i | out_force_x_o .. is_averaged_o
//   config  | in        | cfg_we_i, no wait         | cfg_wdata_i (filter enable)
//
// One item per cycle unless a held result stalls; a result passes the multiply
// and correction registers after the edge that takes its item. Stage one
// updates the running sums from the chain of history cells, the next two
// stages are the per-axis reciprocal multiply and its correction.
// Reset needs no clearing pass: a fill counter tracks which cells hold data.
// A held result stalls the stages behind it; empty stages still take items.
// ----------------------------------------------------------------------------
`default_nettype none

module six_axis_moving_average_top import msa_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cfg_we_i,
  input  logic    cfg_wdata_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  sample_t force_x_i,
  input  sample_t force_y_i,
  input  sample_t force_z_i,
  input  sample_t torque_x_i,
  input  sample_t torque_y_i,
  input  sample_t torque_z_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output sample_t out_force_x_o,
  output sample_t out_force_y_o,
  output sample_t out_force_z_o,
  output sample_t out_torque_x_o,
  output sample_t out_torque_y_o,
  output sample_t out_torque_z_o,
  output logic    is_averaged_o
);

  `include "assert_macros.svh"

  logic             filter_enable_q;
  logic             v1_q, v2_q, v3_q;
  logic             adv1, adv2, adv3;
  logic             in_fire, shift;
  logic             bypass_fire;
  logic [CNT_W-1:0] fill_q;
  logic             window_full_q;
  logic             avg_d;
  logic             avg1_q, avg2_q, avg3_q;
  axes_t            raw;
  axes_t            raw1_q, raw2_q, raw3_q;
  axes_t            cell_in  [WINDOW];
  axes_t            cell_out [WINDOW];
  sums_t            sums_q, sums_d, sum1_q;
  axes_t            mean;
  axes_t            out_sel;
  pipe_ctl_t        ctl;

  // stage advance, each stage moves when it is empty or the next one moves
  assign adv3        = !v3_q || out_ready_i;
  assign adv2        = !v2_q || adv3;
  assign adv1        = !v1_q || adv2;
  assign in_ready_o  = adv1;
  assign in_fire     = in_valid_i && adv1;
  assign shift       = in_fire && filter_enable_q;
  assign bypass_fire = in_fire && !filter_enable_q;
  assign ctl         = '{mul_en: adv2, fix_en: adv3};

  assign raw = '{force_x_i, force_y_i, force_z_i, torque_x_i, torque_y_i, torque_z_i};

  // filter enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      filter_enable_q <= cfg_wdata_i;
    end
  end

  // chain of history cells, newest at the head
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_in[i] = raw;
    end else begin : g_link
      assign cell_in[i] = cell_out[i-1];
    end
    msa_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .data_i (cell_in[i]),
      .data_o (cell_out[i])
    );
  end

  // running sums: add the new sample, drop the oldest once the window is full
  always_comb begin
    for (int j = 0; j < AXES; j++) begin
      sums_d[j] = sums_q[j] + SUM_W'(raw[j])
                - (window_full_q ? SUM_W'(cell_out[WINDOW-1][j]) : SUM_W'(0));
    end
    avg_d = filter_enable_q && (window_full_q || fill_q == CNT_W'(WINDOW - 1));
  end

  // sums and fill tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < AXES; j++) begin
        sums_q[j] <= '0;
      end
      fill_q        <= '0;
      window_full_q <= 1'b0;
    end else if (shift) begin
      sums_q <= sums_d;
      if (!window_full_q) begin
        if (fill_q == CNT_W'(WINDOW - 1)) begin
          fill_q        <= '0;
          window_full_q <= 1'b1;
        end else begin
          fill_q <= fill_q + 1'b1;
        end
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // stage payload: raw samples and averaged flag ride along the divider
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      raw1_q <= raw;
      sum1_q <= sums_d;
      avg1_q <= avg_d;
    end
    if (adv2) begin
      raw2_q <= raw1_q;
      avg2_q <= avg1_q;
    end
    if (adv3) begin
      raw3_q <= raw2_q;
      avg3_q <= avg2_q;
    end
  end

  // per-axis rounded mean
  for (genvar j = 0; j < AXES; j++) begin : g_mean
    msa_mean u_mean (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .sum_i (sum1_q[j]),
      .mean_o(mean[j])
    );
  end

  // result select
  always_comb begin
    for (int j = 0; j < AXES; j++) begin
      out_sel[j] = avg3_q ? mean[j] : raw3_q[j];
    end
  end

  assign out_valid_o    = v3_q;
  assign out_force_x_o  = out_sel[0];
  assign out_force_y_o  = out_sel[1];
  assign out_force_z_o  = out_sel[2];
  assign out_torque_x_o = out_sel[3];
  assign out_torque_y_o = out_sel[4];
  assign out_torque_z_o = out_sel[5];
  assign is_averaged_o  = avg3_q;

  // window stays full once filled
  `MSA_ASSERT(a_full_sticky, window_full_q |=> window_full_q, "window full flag dropped")
  // fill counter stays inside the window, and sits at zero once full
  `MSA_ASSERT_NEVER(a_fill_range, fill_q > CNT_W'(WINDOW - 1), "fill count out of range")
  // a bypassed item leaves the fill tracking alone
  `MSA_ASSERT(a_bypass_fill, bypass_fire |=> $stable(fill_q), "bypass moved fill count")
  // a bypassed item leaves the axis-0 running sum alone
  `MSA_ASSERT(a_bypass_sum, bypass_fire |=> $stable(sums_q[0]), "bypass changed sums")
  // an averaged result only exists once the window has filled
  `MSA_ASSERT(a_avg_full, out_valid_o && is_averaged_o |-> window_full_q, "averaged before fill")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the six-axis boxcar moving average. Items are sent
// in bursts against a receiver that stalls on its own pattern. Every accepted
// item is run through a local running-sum model to predict its result, and
// results are compared in order, axis by axis. Covered: the fill phase,
// extreme values, rounding ties, bypass with state held, and random phases.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import msa_pkg::*;

  typedef struct {
    axes_t axis;
    logic  averaged;
  } filt_result_t;

  typedef enum {READY_ALWAYS, READY_RANDOM, READY_PERIODIC} ready_mode_e;
  typedef enum {VAL_MIX, VAL_HIGH, VAL_LOW, VAL_SMALL} value_style_e;

  localparam sample_t S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // dut signals, all inputs known from time zero
  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    cfg_we_i    = 1'b0;
  logic    cfg_wdata_i = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    out_ready_i = 1'b0;
  sample_t force_x_i   = '0;
  sample_t force_y_i   = '0;
  sample_t force_z_i   = '0;
  sample_t torque_x_i  = '0;
  sample_t torque_y_i  = '0;
  sample_t torque_z_i  = '0;
  logic    in_ready_o;
  logic    out_valid_o;
  sample_t out_force_x_o;
  sample_t out_force_y_o;
  sample_t out_force_z_o;
  sample_t out_torque_x_o;
  sample_t out_torque_y_o;
  sample_t out_torque_z_o;
  logic    is_averaged_o;

  // model of the filter state
  sample_t hist [WINDOW][AXES];
  longint  axis_total [AXES] = '{default: 0};
  int      next_slot = 0;
  bit      ring_full = 1'b0;
  bit      filter_on = 1'b1;

  // bench state
  filt_result_t expected_means [$];
  int           mismatch_count = 0;
  int           burst_left     = 0;
  bit           bursty         = 1'b1;
  ready_mode_e  ready_mode     = READY_ALWAYS;
  int           cycle_count    = 0;

  six_axis_moving_average_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .force_x_i      (force_x_i),
    .force_y_i      (force_y_i),
    .force_z_i      (force_z_i),
    .torque_x_i     (torque_x_i),
    .torque_y_i     (torque_y_i),
    .torque_z_i     (torque_z_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_force_x_o  (out_force_x_o),
    .out_force_y_o  (out_force_y_o),
    .out_force_z_o  (out_force_z_o),
    .out_torque_x_o (out_torque_x_o),
    .out_torque_y_o (out_torque_y_o),
    .out_torque_z_o (out_torque_z_o),
    .is_averaged_o  (is_averaged_o)
  );

  // 20 ns clock
  always #10 clk_i = ~clk_i;

  // running-sum window mean of one sample, rounded half away from zero
  function automatic filt_result_t boxcar_predict(axes_t s);
    filt_result_t r;
    longint       mag;
    int           slot;
    slot       = next_slot;
    r.axis     = s;
    r.averaged = 1'b0;
    if (filter_on) begin
      for (int j = 0; j < AXES; j++) begin
        if (ring_full) axis_total[j] -= hist[slot][j];
        axis_total[j] += s[j];
        hist[slot][j] = s[j];
      end
      r.averaged = ring_full || (slot == WINDOW - 1);
      if (r.averaged) begin
        for (int j = 0; j < AXES; j++) begin
          mag = (axis_total[j] < 0) ? -axis_total[j] : axis_total[j];
          mag = (mag + HALF_WIN) / WINDOW;
          r.axis[j] = sample_t'((axis_total[j] < 0) ? -mag : mag);
        end
      end
      slot++;
      if (slot == WINDOW) begin
        slot      = 0;
        ring_full = 1'b1;
      end
      next_slot = slot;
    end
    return r;
  endfunction

  // random axis value in the style of the current phase
  function automatic sample_t pick_value(value_style_e st);
    case (st)
      VAL_HIGH:  return ($urandom_range(0, 9) < 7) ? S_MAX : sample_t'($urandom);
      VAL_LOW:   return ($urandom_range(0, 9) < 7) ? S_MIN : sample_t'($urandom);
      VAL_SMALL: return sample_t'(int'($urandom_range(0, 64)) - 32);
      default: begin
        case ($urandom_range(0, 7))
          0:       return S_MAX;
          1:       return S_MIN;
          2:       return sample_t'(int'($urandom_range(0, 24)) - 12);
          default: return sample_t'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_count < 200) $display("%0t ns mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // write the filter enable, only while nothing is in flight
  task automatic set_filter(bit en);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    filter_on = en;
  endtask

  // send one item, with bursts and gaps in between
  task automatic send_sample(axes_t s);
    int gap;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      if ($urandom_range(0, 19) == 0) begin
        // hold off until the pipeline has emptied
        @(posedge clk_i);
        while (expected_means.size() != 0) @(posedge clk_i);
      end else begin
        gap = $urandom_range(1, 6);
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    force_x_i  <= s[0];
    force_y_i  <= s[1];
    force_z_i  <= s[2];
    torque_x_i <= s[3];
    torque_y_i <= s[4];
    torque_z_i <= s[5];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_means.insert(expected_means.size(), boxcar_predict(s));
    if (bursty) burst_left--;
  endtask

  // stop sending and let every pending result drain
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_means.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // fill phase with alternating extremes, window mean lands on a tie
  task automatic test_fill_extremes();
    axes_t s;
    for (int k = 0; k < WINDOW; k++) begin
      for (int j = 0; j < AXES; j++) s[j] = ((k + j) % 2 == 0) ? S_MAX : S_MIN;
      send_sample(s);
    end
    drain_results();
  endtask

  // replace the whole window so sums sit on and near half steps
  task automatic test_rounding_ties();
    axes_t s;
    axes_t zero;
    s    = '{sample_t'(6), sample_t'(-6), sample_t'(18), sample_t'(-18),
             sample_t'(5), sample_t'(-7)};
    zero = '{default: '0};
    send_sample(s);
    for (int k = 1; k < WINDOW; k++) send_sample(zero);
    drain_results();
  endtask

  // raw items while disabled, then averaging picks up the held state
  task automatic test_bypass_resume();
    axes_t s;
    set_filter(1'b0);
    s = '{default: S_MAX};
    send_sample(s);
    s = '{default: S_MIN};
    send_sample(s);
    drain_results();
    set_filter(1'b1);
    s = '{sample_t'(1), sample_t'(-1), sample_t'(100), sample_t'(-100),
          S_MAX, S_MIN};
    send_sample(s);
    drain_results();
  endtask

  // random phases with varied enable, stall pattern and value style
  task automatic test_random_phases();
    axes_t        s;
    value_style_e st;
    int           n;
    for (int p = 0; p < 10; p++) begin
      set_filter((p == 2 || p == 6) ? 1'b0 : ($urandom_range(0, 4) != 0));
      ready_mode = ready_mode_e'($urandom_range(0, 2));
      bursty     = ($urandom_range(0, 3) != 0);
      burst_left = bursty ? 0 : 1;
      st         = (p == 0) ? VAL_MIX : value_style_e'($urandom_range(0, 3));
      n          = $urandom_range(90, 120);
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < AXES; j++) s[j] = pick_value(st);
        send_sample(s);
      end
      drain_results();
    end
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    case (ready_mode)
      READY_ALWAYS:   out_ready_i <= 1'b1;
      READY_RANDOM:   out_ready_i <= ($urandom_range(0, 9) < 6);
      READY_PERIODIC: out_ready_i <= ((cycle_count % 9) < 5);
      default:        out_ready_i <= 1'b1;
    endcase
    cycle_count++;
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_result
    filt_result_t want;
    axes_t        got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{out_force_x_o, out_force_y_o, out_force_z_o,
              out_torque_x_o, out_torque_y_o, out_torque_z_o};
      if (expected_means.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = expected_means.pop_front();
        for (int j = 0; j < AXES; j++) begin
          if (got[j] !== want.axis[j])
            report_mismatch($sformatf("axis %0d got %0d want %0d",
                                      j, got[j], want.axis[j]));
        end
        if (is_averaged_o !== want.averaged)
          report_mismatch($sformatf("is_averaged got %b want %b",
                                    is_averaged_o, want.averaged));
      end
    end
  end

  // main sequence
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    ready_mode = READY_RANDOM;
    set_filter(1'b1);
    test_fill_extremes();
    test_rounding_ties();
    test_bypass_resume();
    test_random_phases();
    if (expected_means.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_means.size()));
    if (mismatch_count == 0) begin
      $display("six_axis_moving_average_top test passed");
    end else begin
      $display("six_axis_moving_average_top test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("six_axis_moving_average_top test failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/msa_pkg.sv
sv/msa_cell.sv
sv/msa_mean.sv
sv/six_axis_moving_average_top.sv
tb/tb_top.sv
